// File: src/btpc_pkg.sv
// shared types and constants for the barometric compensation pipeline
package btpc_pkg;

   // one quotient bit per divider stage
   localparam int DIV_STAGES = 64;

   // offset of the fine temperature used by the pressure path
   localparam int FINE_OFFSET = 128000;
   // full-scale raw pressure count
   localparam int PRESS_BASE = 1048576;
   // pressure numerator scale
   localparam int PRESS_SCALE = 3125;
   // bias added to the pressure divisor term
   localparam logic [63:0] DEN_BIAS = 64'h0000_8000_0000_0000;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_TEMP_CALIB = 2'd0,
      REG_PRESS_LOW  = 2'd1,
      REG_PRESS_MID  = 2'd2,
      REG_PRESS_LAST = 2'd3
   } reg_index_type;

   // unpacked calibration words
   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } calib_type;

   // per-request data that rides beside the divider
   typedef struct packed {
      logic [31:0] temp;
      logic        err;
      logic        neg;
   } side_type;

endpackage

// File: src/btpc_front.sv
// temperature compensation and pressure numerator / divisor stages
module btpc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_vld,
   input  logic [19:0]          raw_t,
   input  logic [19:0]          raw_p,
   input  btpc_pkg::calib_type  cal,
   output logic                 out_vld,
   output logic [63:0]          num_mag,
   output logic [30:0]          den_mag,
   output btpc_pkg::side_type   side
);
   import btpc_pkg::*;

   localparam int NSTG = 10;

   logic [NSTG-1:0] vld_ff;

   // stage 1: first temperature terms
   logic signed [18:0] s1_a;
   logic signed [17:0] s1_d;
   logic signed [34:0] s1_ta_prod_in, s1_ta_prod_ff;
   logic signed [35:0] s1_dd_in, s1_dd_ff;
   logic [19:0]        rp_ff [0:5];

   assign s1_a = $signed({2'b00, raw_t[19:3]}) - $signed({2'b00, cal.t1, 1'b0});
   assign s1_d = $signed({2'b00, raw_t[19:4]}) - $signed({2'b00, cal.t1});
   assign s1_ta_prod_in = s1_a * $signed(cal.t2);
   assign s1_dd_in = s1_d * s1_d;

   // stage 2: scale and second temperature product
   logic signed [23:0] s2_ta_in, s2_ta_ff;
   logic signed [38:0] s2_tb_prod_in, s2_tb_prod_ff;

   assign s2_ta_in = s1_ta_prod_ff[34:11];
   assign s2_tb_prod_in = $signed({1'b0, s1_dd_ff[33:12]}) * $signed(cal.t3);

   // stage 3: fine temperature
   logic signed [25:0] s3_fine_in, s3_fine_ff;

   assign s3_fine_in = s2_ta_ff + $signed(s2_tb_prod_ff[38:14]);

   // stage 4: temperature result and pressure offset term
   logic signed [28:0] s4_t5;
   logic [31:0]        s4_temp_in, s4_temp_ff;
   logic signed [26:0] s4_x_in, s4_x_ff;

   assign s4_t5 = s3_fine_ff * 29'sd5 + 29'sd128;
   assign s4_temp_in = {{11{s4_t5[28]}}, s4_t5[28:8]};
   assign s4_x_in = s3_fine_ff - 27'(FINE_OFFSET);

   // stage 5: products of the offset term
   logic signed [53:0] s5_xx_in, s5_xx_ff;
   logic signed [42:0] s5_xp5_in, s5_xp5_ff;
   logic signed [42:0] s5_xp2_in, s5_xp2_ff;
   logic [31:0]        tdly_ff [0:4];

   assign s5_xx_in = s4_x_ff * s4_x_ff;
   assign s5_xp5_in = s4_x_ff * $signed(cal.p5);
   assign s5_xp2_in = s4_x_ff * $signed(cal.p2);

   // stage 6: square terms scaled by p6 and p3, wrapped to 64 bits
   logic signed [69:0] s6_y1_full, s6_x3_full;
   logic [63:0]        s6_y1_ff, s6_x3_ff;
   logic signed [42:0] s6_xp5_ff, s6_xp2_ff;

   assign s6_y1_full = s5_xx_ff * $signed(cal.p6);
   assign s6_x3_full = s5_xx_ff * $signed(cal.p3);

   // stage 7: sum the numerator and divisor terms
   logic [63:0] s7_y_in, s7_y_ff;
   logic [63:0] s7_x2_in, s7_x2_ff;
   logic [20:0] s7_pp_in, s7_pp_ff;

   assign s7_y_in = s6_y1_ff + ({{21{s6_xp5_ff[42]}}, s6_xp5_ff} << 17)
                  + ({{48{cal.p4[15]}}, cal.p4} << 35);
   assign s7_x2_in = {{8{s6_x3_ff[63]}}, s6_x3_ff[63:8]}
                   + ({{21{s6_xp2_ff[42]}}, s6_xp2_ff} << 12) + DEN_BIAS;
   assign s7_pp_in = 21'(PRESS_BASE) - {1'b0, rp_ff[5]};

   // stage 8: divisor product and raw numerator
   logic signed [80:0] s8_x1_full;
   logic [63:0]        s8_x1_ff;
   logic [63:0]        s8_num_in, s8_num_ff;

   assign s8_x1_full = $signed(s7_x2_ff) * $signed({1'b0, cal.p1});
   assign s8_num_in = {12'b0, s7_pp_ff, 31'b0} - s7_y_ff;

   // stage 9: scaled numerator and final divisor
   logic [63:0] s9_num_in, s9_num_ff;
   logic [30:0] s9_den_ff;

   assign s9_num_in = s8_num_ff * 64'(PRESS_SCALE);

   // stage 10: magnitudes and sign for the divider
   logic [63:0] s10_num_in, s10_num_ff;
   logic [30:0] s10_den_in, s10_den_ff;
   side_type    s10_side_in, s10_side_ff;

   assign s10_num_in = s9_num_ff[63] ? (64'd0 - s9_num_ff) : s9_num_ff;
   assign s10_den_in = s9_den_ff[30] ? (31'd0 - s9_den_ff) : s9_den_ff;
   always_comb begin
      s10_side_in.temp = tdly_ff[4];
      s10_side_in.err  = (s9_den_ff == 31'd0);
      s10_side_in.neg  = s9_num_ff[63] ^ s9_den_ff[30];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_vld};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ta_prod_ff <= s1_ta_prod_in;
         s1_dd_ff      <= s1_dd_in;
         rp_ff[0]      <= raw_p;
         for (int i = 1; i < 6; i++) begin
            rp_ff[i] <= rp_ff[i-1];
         end
         s2_ta_ff      <= s2_ta_in;
         s2_tb_prod_ff <= s2_tb_prod_in;
         s3_fine_ff    <= s3_fine_in;
         s4_temp_ff    <= s4_temp_in;
         s4_x_ff       <= s4_x_in;
         s5_xx_ff      <= s5_xx_in;
         s5_xp5_ff     <= s5_xp5_in;
         s5_xp2_ff     <= s5_xp2_in;
         tdly_ff[0]    <= s4_temp_ff;
         for (int i = 1; i < 5; i++) begin
            tdly_ff[i] <= tdly_ff[i-1];
         end
         s6_y1_ff      <= s6_y1_full[63:0];
         s6_x3_ff      <= s6_x3_full[63:0];
         s6_xp5_ff     <= s5_xp5_ff;
         s6_xp2_ff     <= s5_xp2_ff;
         s7_y_ff       <= s7_y_in;
         s7_x2_ff      <= s7_x2_in;
         s7_pp_ff      <= s7_pp_in;
         s8_x1_ff      <= s8_x1_full[63:0];
         s8_num_ff     <= s8_num_in;
         s9_num_ff     <= s9_num_in;
         s9_den_ff     <= s8_x1_ff[63:33];
         s10_num_ff    <= s10_num_in;
         s10_den_ff    <= s10_den_in;
         s10_side_ff   <= s10_side_in;
      end
   end

   assign out_vld = vld_ff[NSTG-1];
   assign num_mag = s10_num_ff;
   assign den_mag = s10_den_ff;
   assign side    = s10_side_ff;

endmodule

// File: src/btpc_div.sv
// pipelined restoring divider, one quotient bit per stage
module btpc_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  logic [63:0]         num,
   input  logic [30:0]         den,
   input  btpc_pkg::side_type  in_side,
   output logic                out_vld,
   output logic [63:0]         quo,
   output btpc_pkg::side_type  out_side
);
   import btpc_pkg::*;

   logic [DIV_STAGES-1:0] vld_ff;
   logic [63:0]           n_ff   [DIV_STAGES];
   logic [30:0]           rem_ff [DIV_STAGES];
   logic [30:0]           d_ff   [DIV_STAGES];
   side_type              sd_ff  [DIV_STAGES];

   // stage inputs: ports for the first, previous stage otherwise
   logic [63:0] n_w   [DIV_STAGES];
   logic [30:0] rem_w [DIV_STAGES];
   logic [30:0] d_w   [DIV_STAGES];
   side_type    sd_w  [DIV_STAGES];

   assign n_w[0]   = num;
   assign rem_w[0] = '0;
   assign d_w[0]   = den;
   assign sd_w[0]  = in_side;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_STAGES-2:0], in_vld};
      end
   end

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic [31:0] trial;
      logic        ge;
      logic [31:0] diff;

      if (i > 0) begin : g_link
         assign n_w[i]   = n_ff[i-1];
         assign rem_w[i] = rem_ff[i-1];
         assign d_w[i]   = d_ff[i-1];
         assign sd_w[i]  = sd_ff[i-1];
      end

      // shift in the next dividend bit and try the subtract
      assign trial = {rem_w[i], n_w[i][63]};
      assign ge    = (trial >= {1'b0, d_w[i]});
      assign diff  = trial - {1'b0, d_w[i]};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= ge ? diff[30:0] : trial[30:0];
            n_ff[i]   <= {n_w[i][62:0], ge};
            d_ff[i]   <= d_w[i];
            sd_ff[i]  <= sd_w[i];
         end
      end
   end

   assign out_vld  = vld_ff[DIV_STAGES-1];
   assign quo      = n_ff[DIV_STAGES-1];
   assign out_side = sd_ff[DIV_STAGES-1];

endmodule

// File: src/btpc_back.sv
// pressure correction, saturation and output register
module btpc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  logic [63:0]         quo,
   input  btpc_pkg::side_type  in_side,
   input  btpc_pkg::calib_type cal,
   output logic                out_vld,
   output logic [31:0]         temperature_centi,
   output logic [31:0]         pressure_q24_8,
   output logic                status
);
   import btpc_pkg::*;

   localparam int NSTG = 6;

   logic [NSTG-1:0] vld_ff;
   side_type        sd_ff [0:NSTG-2];

   // stage 1: signed quotient
   logic [63:0] b1_q_in, b1_q_ff;

   assign b1_q_in = in_side.neg ? (64'd0 - quo) : quo;

   // stage 2: square of the scaled quotient as partial products, p8 term
   logic [63:0]        b2_e;
   logic [63:0]        b2_pp0_in, b2_pp0_ff;
   logic [31:0]        b2_pp1_in, b2_pp1_ff;
   logic signed [79:0] b2_c2_full;
   logic [63:0]        b2_c2p_ff, b2_q_ff;

   assign b2_e       = {{13{b1_q_ff[63]}}, b1_q_ff[63:13]};
   assign b2_pp0_in  = 64'(b2_e[31:0]) * 64'(b2_e[31:0]);
   assign b2_pp1_in  = b2_e[31:0] * b2_e[63:32];
   assign b2_c2_full = $signed(b1_q_ff) * $signed(cal.p8);

   // stage 3: combine the partial products
   logic [63:0] b3_ee_in, b3_ee_ff, b3_c2_in, b3_c2_ff, b3_q_ff;

   assign b3_ee_in = b2_pp0_ff + {b2_pp1_ff[30:0], 33'b0};
   assign b3_c2_in = {{19{b2_c2p_ff[63]}}, b2_c2p_ff[63:19]};

   // stage 4: p9 term
   logic signed [79:0] b4_c1_full;
   logic [63:0]        b4_c1p_ff, b4_c2_ff, b4_q_ff;

   assign b4_c1_full = $signed(b3_ee_ff) * $signed(cal.p9);

   // stage 5: correction sum
   logic [63:0] b5_s_in, b5_s_ff;

   assign b5_s_in = b4_q_ff + {{25{b4_c1p_ff[63]}}, b4_c1p_ff[63:25]} + b4_c2_ff;

   // stage 6: final offset, clamp and error masking
   logic [63:0] b6_r;
   logic [31:0] b6_sat;

   assign b6_r = {{8{b5_s_ff[63]}}, b5_s_ff[63:8]} + ({{48{cal.p7[15]}}, cal.p7} << 4);
   always_comb begin
      if (b6_r[63]) begin
         b6_sat = '0;
      end else if (b6_r[62:32] != '0) begin
         b6_sat = '1;
      end else begin
         b6_sat = b6_r[31:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_vld};
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= in_side;
         for (int i = 1; i < NSTG-1; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end
         b1_q_ff   <= b1_q_in;
         b2_pp0_ff <= b2_pp0_in;
         b2_pp1_ff <= b2_pp1_in;
         b2_c2p_ff <= b2_c2_full[63:0];
         b2_q_ff   <= b1_q_ff;
         b3_ee_ff  <= b3_ee_in;
         b3_c2_ff  <= b3_c2_in;
         b3_q_ff   <= b2_q_ff;
         b4_c1p_ff <= b4_c1_full[63:0];
         b4_c2_ff  <= b3_c2_ff;
         b4_q_ff   <= b3_q_ff;
         b5_s_ff   <= b5_s_in;
         temperature_centi <= sd_ff[NSTG-2].err ? 32'd0 : sd_ff[NSTG-2].temp;
         pressure_q24_8    <= sd_ff[NSTG-2].err ? 32'd0 : b6_sat;
         status            <= sd_ff[NSTG-2].err;
      end
   end

   assign out_vld = vld_ff[NSTG-1];

endmodule

// File: src/baro_temp_pressure_compensation.sv
// top level: register port, calibration words and the compensation pipeline
//
// Takes one request per clock unless stalled, returns one result per request,
// in order. The pipeline has 10 front stages (temperature, pressure
// numerator and divisor), 64 stages of the one-bit-per-stage divider that
// forms the pressure quotient, and 6 back stages ending in the output
// register. The whole pipeline advances together and holds while a result
// waits on rsp_tready. Calibration words sit in four registers of up to 64 bits
// at byte addresses 0, 8, 16 and 24 and must only change while no request
// is in flight. A zero pressure divisor gives zero results with status set.
module baro_temp_pressure_compensation (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // raw_temperature [19:0], raw_pressure [39:20]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // temperature_centi [31:0], pressure_q24_8 [63:32]
   output logic        rsp_tuser,   // status [0]
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import btpc_pkg::*;

   logic [47:0]   temp_calib_ff;
   logic [63:0]   press_low_ff;
   logic [63:0]   press_mid_ff;
   logic [15:0]   press_last_ff;
   reg_index_type csr_idx;
   logic          csr_wr;
   calib_type     cal;
   logic          en;

   // register port
   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[4:3]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_low_ff  <= '0;
         press_mid_ff  <= '0;
         press_last_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_TEMP_CALIB: temp_calib_ff <= csr_pwdata[47:0];
            REG_PRESS_LOW:  press_low_ff  <= csr_pwdata;
            REG_PRESS_MID:  press_mid_ff  <= csr_pwdata;
            REG_PRESS_LAST: press_last_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_TEMP_CALIB: csr_prdata = {16'b0, temp_calib_ff};
         REG_PRESS_LOW:  csr_prdata = press_low_ff;
         REG_PRESS_MID:  csr_prdata = press_mid_ff;
         REG_PRESS_LAST: csr_prdata = {48'b0, press_last_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // unpack calibration words
   always_comb begin
      cal.t1 = temp_calib_ff[15:0];
      cal.t2 = temp_calib_ff[31:16];
      cal.t3 = temp_calib_ff[47:32];
      cal.p1 = press_low_ff[15:0];
      cal.p2 = press_low_ff[31:16];
      cal.p3 = press_low_ff[47:32];
      cal.p4 = press_low_ff[63:48];
      cal.p5 = press_mid_ff[15:0];
      cal.p6 = press_mid_ff[31:16];
      cal.p7 = press_mid_ff[47:32];
      cal.p8 = press_mid_ff[63:48];
      cal.p9 = press_last_ff;
   end

   // pipeline advance: output register empty or being taken
   assign en         = rsp_tready | ~rsp_tvalid;
   assign req_tready = en;

   logic        f_vld;
   logic [63:0] f_num;
   logic [30:0] f_den;
   side_type    f_side;
   logic        d_vld;
   logic [63:0] d_quo;
   side_type    d_side;

   btpc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_tvalid),
      .raw_t   (req_tdata[19:0]),
      .raw_p   (req_tdata[39:20]),
      .cal     (cal),
      .out_vld (f_vld),
      .num_mag (f_num),
      .den_mag (f_den),
      .side    (f_side)
   );

   btpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (f_vld),
      .num      (f_num),
      .den      (f_den),
      .in_side  (f_side),
      .out_vld  (d_vld),
      .quo      (d_quo),
      .out_side (d_side)
   );

   btpc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .en                (en),
      .in_vld            (d_vld),
      .quo               (d_quo),
      .in_side           (d_side),
      .cal               (cal),
      .out_vld           (rsp_tvalid),
      .temperature_centi (rsp_tdata[31:0]),
      .pressure_q24_8    (rsp_tdata[63:32]),
      .status            (rsp_tuser)
   );

`ifndef ASSERT_OFF
   // an error result carries zero data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 64'd0)
      else $error("error result with nonzero data");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // a waiting result stays valid and unchanged
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
`endif

endmodule

// File: verif/btpc_checker.sv
// checker: predicts compensated results and compares them with the result channel
`timescale 1ns / 100ps
module btpc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          results_pending
);
   import btpc_pkg::*;

   typedef struct {
      logic [31:0] temp_centi;
      logic [31:0] press_q24_8;
      logic        status;
   } comp_result_type;

   // shadow copy of the calibration registers
   logic [63:0] cal_temp, cal_plow, cal_pmid, cal_plast;
   comp_result_type awaited_results[$];

   function automatic longint sx16(logic [15:0] w);
      return longint'(signed'(w));
   endfunction

   // integer compensation of one raw sample pair
   function automatic comp_result_type compensate(logic [19:0] rt_raw, logic [19:0] rp_raw);
      longint rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint ta, dt, tb, fine, temp, x, y, num, q, e, c1, c2, r;
      comp_result_type res;
      rt = longint'({44'd0, rt_raw});
      rp = longint'({44'd0, rp_raw});
      t1 = longint'({48'd0, cal_temp[15:0]});
      t2 = sx16(cal_temp[31:16]);
      t3 = sx16(cal_temp[47:32]);
      p1 = longint'({48'd0, cal_plow[15:0]});
      p2 = sx16(cal_plow[31:16]);
      p3 = sx16(cal_plow[47:32]);
      p4 = sx16(cal_plow[63:48]);
      p5 = sx16(cal_pmid[15:0]);
      p6 = sx16(cal_pmid[31:16]);
      p7 = sx16(cal_pmid[47:32]);
      p8 = sx16(cal_pmid[63:48]);
      p9 = sx16(cal_plast[15:0]);
      // fine temperature
      ta = (((rt >>> 3) - (t1 <<< 1)) * t2) >>> 11;
      dt = (rt >>> 4) - t1;
      tb = (((dt * dt) >>> 12) * t3) >>> 14;
      fine = ta + tb;
      temp = (fine * 5 + 128) >>> 8;
      // pressure terms, wrapping 64-bit
      x = fine - 128000;
      y = x * x * p6;
      y = y + ((x * p5) <<< 17);
      y = y + (p4 <<< 35);
      x = ((x * x * p3) >>> 8) + ((x * p2) <<< 12);
      x = (((64'sd1 <<< 47) + x) * p1) >>> 33;
      if (x == 0) begin
         res.temp_centi = '0;
         res.press_q24_8 = '0;
         res.status = 1'b1;
         return res;
      end
      num = 1048576 - rp;
      num = ((num <<< 31) - y) * 3125;
      if (x == -1) q = -num;
      else q = num / x;
      e = q >>> 13;
      c1 = (p9 * e * e) >>> 25;
      c2 = (p8 * q) >>> 19;
      r = ((q + c1 + c2) >>> 8) + (p7 <<< 4);
      res.temp_centi = temp[31:0];
      if (r < 0) res.press_q24_8 = '0;
      else if (r > 64'sh0000_0000_FFFF_FFFF) res.press_q24_8 = '1;
      else res.press_q24_8 = r[31:0];
      res.status = 1'b0;
      return res;
   endfunction

   assign results_pending = awaited_results.size();

   always @(posedge clock) begin
      comp_result_type want;
      if (reset) begin
         cal_temp <= '0;
         cal_plow <= '0;
         cal_pmid <= '0;
         cal_plast <= '0;
         mismatch_count <= 0;
         awaited_results.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:3]))
               REG_TEMP_CALIB: cal_temp <= {16'd0, csr_pwdata[47:0]};
               REG_PRESS_LOW:  cal_plow <= csr_pwdata;
               REG_PRESS_MID:  cal_pmid <= csr_pwdata;
               REG_PRESS_LAST: cal_plast <= {48'd0, csr_pwdata[15:0]};
               default: ;
            endcase
         end
         // accepted request
         if (req_tvalid && req_tready)
            awaited_results.push_back(compensate(req_tdata[19:0], req_tdata[39:20]));
         // accepted result
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected result data=%h status=%b",
                           $realtime, rsp_tdata, rsp_tuser);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_tdata[31:0] !== want.temp_centi ||
                   rsp_tdata[63:32] !== want.press_q24_8 ||
                   rsp_tuser !== want.status) begin
                  if (mismatch_count < 10)
                     $display({"%0t: mismatch temp exp %h got %h, ",
                               "press exp %h got %h, status exp %b got %b"},
                              $realtime, want.temp_centi, rsp_tdata[31:0],
                              want.press_q24_8, rsp_tdata[63:32],
                              want.status, rsp_tuser);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

// File: verif/tb_baro_temp_pressure_compensation.sv
// testbench top: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 100ps
module tb_baro_temp_pressure_compensation;
   import btpc_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int RANDOM_PER_PHASE = 200;
   localparam int NUM_PHASES = 7;

   logic        clock;
   logic        reset;
   logic        req_tvalid, req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [63:0] csr_pwdata, csr_prdata;
   logic        csr_pready;
   int          mismatch_count, results_pending;
   logic        req_took, rsp_took;
   int          idle_cycles;
   int          results_seen;

   baro_temp_pressure_compensation u_top (.*);

   btpc_checker u_checker (.*);

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // handshake flags seen at the edge, read at the next falling edge
   always @(posedge clock) begin
      req_took <= req_tvalid && req_tready;
      rsp_took <= rsp_tvalid && rsp_tready;
   end

   // watchdog on cycles with no request or result moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_baro_temp_pressure_compensation: FAIL");
            $finish;
         end
      end
   end

   // register write over the configuration port
   task automatic csr_write(reg_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {idx, 3'b000};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // one request with a random gap before it
   task automatic send_request(logic [19:0] rt, logic [19:0] rp);
      int gap;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {rp, rt};
      req_tvalid = 1'b1;
      do @(negedge clock); while (!req_took);
   endtask

   task automatic drain_results();
      req_tvalid = 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   // receiver: random stalls, one long hold so the pipeline backs up
   initial begin
      rsp_tready = 1'b0;
      results_seen = 0;
      @(negedge reset);
      forever begin
         int gap;
         gap = $urandom_range(0, 5);
         if (results_seen > 600 && results_seen < 800) gap = 0;
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(negedge clock); while (!rsp_took);
         results_seen++;
         if (results_seen == 300) begin
            rsp_tready = 1'b0;
            repeat (400) @(negedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin
      logic [63:0] cal[4];
      logic [19:0] rt, rp;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            // typical factory calibration
            0: begin
               cal[0] = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
               cal[1] = {16'd2855, 16'd3024, 16'hD743, 16'd36477};
               cal[2] = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
               cal[3] = 64'd6000;
            end
            // all zero: zero divisor everywhere
            1: begin
               cal[0] = '0; cal[1] = '0; cal[2] = '0; cal[3] = '0;
            end
            // all ones
            2: begin
               cal[0] = '1; cal[1] = '1; cal[2] = '1; cal[3] = '1;
            end
            // most positive signed words, largest unsigned ones
            3: begin
               cal[0] = {16'd0, 16'h7FFF, 16'h7FFF, 16'hFFFF};
               cal[1] = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF};
               cal[2] = {4{16'h7FFF}};
               cal[3] = 64'h7FFF;
            end
            // most negative signed words
            4: begin
               cal[0] = {16'd0, 16'h8000, 16'h8000, 16'h0001};
               cal[1] = {16'h8000, 16'h8000, 16'h8000, 16'h0001};
               cal[2] = {4{16'h8000}};
               cal[3] = 64'h8000;
            end
            default: begin
               for (int i = 0; i < 4; i++) cal[i] = {$urandom, $urandom};
            end
         endcase
         csr_write(REG_TEMP_CALIB, cal[0]);
         csr_write(REG_PRESS_LOW, cal[1]);
         csr_write(REG_PRESS_MID, cal[2]);
         csr_write(REG_PRESS_LAST, cal[3]);

         // field extremes and a typical sample
         if (ph < 2) begin
            send_request(20'd0, 20'd0);
            send_request(20'hFFFFF, 20'hFFFFF);
            send_request(20'd0, 20'hFFFFF);
            send_request(20'hFFFFF, 20'd0);
            send_request(20'd519888, 20'd415148);
            send_request(20'h80000, 20'h80000);
            send_request(20'h7FFFF, 20'h7FFFF);
            send_request(20'd440064, 20'd1);
         end

         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if ($urandom_range(0, 1) == 0) begin
               rt = 20'($urandom_range(400000, 600000));
               rp = 20'($urandom_range(200000, 500000));
            end else begin
               rt = 20'($urandom);
               rp = 20'($urandom);
            end
            send_request(rt, rp);
         end
         // sender waits for every result before the next setting
         drain_results();
      end

      repeat (100) @(negedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("tb_baro_temp_pressure_compensation: PASS");
      end else begin
         $display("tb_baro_temp_pressure_compensation: FAIL");
      end
      $finish;
   end

endmodule
